// ===== src/efcm_pkg.sv =====
// Package for the echogram false-color mapper: theme stop tables and helpers.
// No dependencies.
`default_nettype none
package efcm_pkg;
	localparam int NumThemes = 10;
	localparam int MaxStops = 11;

	typedef logic [3:0] stop_idx_t;
	typedef logic [7:0] byte_t;

	typedef struct packed {
		byte_t l0;
		byte_t l1;
		byte_t r0;
		byte_t g0;
		byte_t b0;
		byte_t r1;
		byte_t g1;
		byte_t b1;
	} seg_t;

	function automatic logic [3:0] stop_count(input logic [3:0] th);
		case (th)
			4'd0: stop_count = 4'd5;
			4'd1: stop_count = 4'd4;
			4'd2: stop_count = 4'd8;
			4'd3: stop_count = 4'd6;
			4'd4: stop_count = 4'd3;
			4'd5: stop_count = 4'd3;
			4'd6: stop_count = 4'd11;
			4'd7: stop_count = 4'd9;
			4'd8: stop_count = 4'd10;
			4'd9: stop_count = 4'd10;
			default: stop_count = 4'd5;
		endcase
	endfunction

	function automatic byte_t stop_level(input logic [3:0] th, input stop_idx_t k);
		logic [87:0] row;
		case (th)
			4'd1: row = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd130,
				8'd30, 8'd0};
			4'd2: row = {8'd0, 8'd0, 8'd0, 8'd255, 8'd200, 8'd140, 8'd92, 8'd52, 8'd26,
				8'd12, 8'd0};
			4'd3: row = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd150, 8'd120, 8'd80,
				8'd30, 8'd0};
			4'd4, 4'd5: row = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255,
				8'd150, 8'd0};
			4'd6: row = {8'd255, 8'd235, 8'd210, 8'd185, 8'd150, 8'd120, 8'd90, 8'd60,
				8'd36, 8'd18, 8'd0};
			4'd7: row = {8'd0, 8'd0, 8'd255, 8'd235, 8'd210, 8'd170, 8'd130, 8'd95,
				8'd60, 8'd30, 8'd0};
			4'd8: row = {8'd0, 8'd255, 8'd220, 8'd190, 8'd160, 8'd130, 8'd100, 8'd70,
				8'd45, 8'd20, 8'd0};
			4'd9: row = {8'd0, 8'd255, 8'd224, 8'd196, 8'd168, 8'd140, 8'd112, 8'd84,
				8'd56, 8'd28, 8'd0};
			default: row = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd220, 8'd130,
				8'd30, 8'd0};
		endcase
		stop_level = (k < 4'd11) ? row[k*8 +: 8] : 8'd0;
	endfunction

	function automatic logic [23:0] stop_rgb(input logic [3:0] th, input stop_idx_t k);
		logic [263:0] row;
		case (th)
			4'd1: row = {168'd0, 24'hFFFFDC, 24'hE6C864, 24'h32320A, 24'h000000};
			4'd2: row = {72'd0, 24'hFFE8A0, 24'hF5AF46, 24'hD2690F, 24'h96460A,
				24'h5F2300, 24'h371200, 24'h1C0A00, 24'h000000};
			4'd3: row = {120'd0, 24'hFFFFFF, 24'hFF3214, 24'h14E61E, 24'h001E96,
				24'h280050, 24'h000000};
			4'd4: row = {192'd0, 24'hE6FFFF, 24'hBEC8C8, 24'h000000};
			4'd5: row = {192'd0, 24'h000000, 24'h464646, 24'hE6FFFF};
			4'd6: row = {24'hFFFFFF, 24'hFF2828, 24'hFF7800, 24'hDCFF00, 24'h00FF50,
				24'h00FFC8, 24'h00C8FF, 24'h005AFF, 24'h2800C8, 24'h140078, 24'h000028};
			4'd7: row = {48'd0, 24'hFFFFFF, 24'hE6FFFF, 24'hAAFFFF, 24'h50FFE6,
				24'h00F0FF, 24'h00B4FF, 24'h0064E6, 24'h002896, 24'h000046};
			4'd8: row = {24'd0, 24'hFFFFFF, 24'hFFFF50, 24'hC8FF00, 24'h78FF00,
				24'h00FF00, 24'h00DC00, 24'h00A000, 24'h006400, 24'h003200, 24'h000000};
			4'd9: row = {24'd0, 24'hFFB31A, 24'hE69933, 24'hCC804D, 24'hB36666,
				24'h994D80, 24'h803399, 24'h6633B3, 24'h4D4DCC, 24'h3366E6, 24'h3380FF};
			default: row = {144'd0, 24'hFFFFFF, 24'hBEF0FA, 24'h32B4E6, 24'h140550,
				24'h000000};
		endcase
		stop_rgb = (k < 4'd11) ? row[k*24 +: 24] : 24'd0;
	endfunction
endpackage
`default_nettype wire

// ===== src/echogram_false_color_mapper.sv =====
// Request to result strobe runs through the remap pipeline and then the blend pipeline,
// each with a two-stage compare-and-subtract divide; throughput one request per cycle.
// busy is always low, so a request may be given every cycle; results cannot be held off.
// Reset (arst_n low) clears the pipeline valid bits and restores theme 0,
// low level 10, high level 100.
`default_nettype none
module echogram_false_color_mapper import efcm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [7:0] intensity,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [6:0] cfg_data,
	output logic            done,
	output logic [7:0]      level_index,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue
);
	localparam logic [1:0] RegTheme = 2'd0;
	localparam logic [1:0] RegLow   = 2'd1;
	localparam logic [1:0] RegHigh  = 2'd2;

	logic [3:0] theme_q;
	logic [6:0] low_q, high_q;
	logic       rv;
	logic [7:0] ridx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			theme_q <= 4'd0;
			low_q   <= 7'd10;
			high_q  <= 7'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegTheme: theme_q <= cfg_data[3:0];
				RegLow:   low_q   <= cfg_data;
				RegHigh:  high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	efcm_remap u_remap (
		.clk(clk), .arst_n(arst_n), .in_vld(start), .intensity(intensity),
		.low_level(low_q), .high_level(high_q), .out_vld(rv), .idx(ridx)
	);

	efcm_blend u_blend (
		.clk(clk), .arst_n(arst_n), .in_vld(rv), .idx(ridx), .theme(theme_q),
		.out_vld(done), .idx_out(level_index), .red(red), .green(green), .blue(blue)
	);

`ifndef SYNTHESIS
	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy);
	a_done_known: assert property (@(posedge clk) disable iff (!arst_n) !$isunknown(done));
	a_done_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 8));
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown({level_index, red, green, blue}));
`endif
endmodule
`default_nettype wire

// ===== src/efcm_remap.sv =====
// Window-level remap: intensity to palette index over four stages.
// Depends on efcm_pkg.
`default_nettype none
module efcm_remap import efcm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_vld,
	input  wire logic [7:0] intensity,
	input  wire logic [6:0] low_level,
	input  wire logic [6:0] high_level,
	output logic            out_vld,
	output logic [7:0]      idx
);
	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [9:0]  d_s1;
	logic [6:0]  span_s1;
	logic        step_s1;
	logic signed [16:0] num_s2;
	logic [6:0]  span_s2;
	logic        step_s2;
	logic [15:0] rem_s3;
	logic [3:0]  qhi_s3;
	logic [6:0]  span_s3;
	logic        sat_s3;
	logic [7:0]  sat_val_s3;
	logic [7:0]  idx_s4;

	logic [9:0]  five_low;
	logic [8:0]  offset;
	logic [15:0] nmag;
	logic [15:0] rem_a;
	logic [3:0]  q_a;
	logic [15:0] rem_b;
	logic [3:0]  q_b;

	assign five_low = {1'b0, low_level, 2'b0} + {3'b0, low_level};
	assign offset   = five_low[9:1];

	always_ff @(posedge clk) begin
		d_s1    <= $signed({2'b0, intensity}) - $signed({1'b0, offset});
		span_s1 <= high_level - low_level;
		step_s1 <= high_level <= low_level;
		num_s2  <= d_s1 * 8'sd100;
		span_s2 <= span_s1;
		step_s2 <= step_s1;
	end

	assign nmag = num_s2[16] ? 16'd0 : num_s2[15:0];

	always_comb begin
		rem_a = nmag;
		q_a   = '0;
		for (int i = 3; i >= 0; i--) begin
			if (rem_a >= ({9'd0, span_s2} << (i + 4))) begin
				rem_a  = rem_a - ({9'd0, span_s2} << (i + 4));
				q_a[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rem_s3  <= rem_a;
		qhi_s3  <= q_a;
		span_s3 <= span_s2;
		if (step_s2) begin
			sat_s3     <= 1'b1;
			sat_val_s3 <= (num_s2 > 17'sd0) ? 8'd255 : 8'd0;
		end else if (num_s2[16]) begin
			sat_s3     <= 1'b1;
			sat_val_s3 <= 8'd0;
		end else if (nmag >= {1'b0, span_s2, 8'd0}) begin
			sat_s3     <= 1'b1;
			sat_val_s3 <= 8'd255;
		end else begin
			sat_s3     <= 1'b0;
			sat_val_s3 <= 8'd0;
		end
	end

	always_comb begin
		rem_b = rem_s3;
		q_b   = '0;
		for (int i = 3; i >= 0; i--) begin
			if (rem_b >= ({9'd0, span_s3} << i)) begin
				rem_b  = rem_b - ({9'd0, span_s3} << i);
				q_b[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s4 <= sat_s3 ? sat_val_s3 : {qhi_s3, q_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign out_vld = vld_s4;
	assign idx     = idx_s4;
endmodule
`default_nettype wire

// ===== src/efcm_blend.sv =====
// Segment select and per-channel interpolation over four stages.
// Depends on efcm_pkg.
`default_nettype none
module efcm_blend import efcm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_vld,
	input  wire logic [7:0] idx,
	input  wire logic [3:0] theme,
	output logic            out_vld,
	output logic [7:0]      idx_out,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue
);
	logic       vld_s1, vld_s2, vld_s3, vld_s4;
	seg_t       seg_s1;
	logic [7:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic [16:0] num_s2 [3];
	logic [8:0]  den_s2;
	logic [17:0] rem_s3 [3];
	logic [3:0]  qhi_s3 [3];
	logic [8:0]  den_s3;
	logic [7:0]  ch_s4 [3];

	logic [3:0] th;
	stop_idx_t  k;
	logic [3:0] n;
	assign th = (theme < 4'(NumThemes)) ? theme : 4'd0;
	assign n  = stop_count(th);

	always_comb begin
		k = '0;
		for (int j = 1; j < MaxStops - 1; j++)
			if (4'(j) + 4'd1 < n && idx > stop_level(th, 4'(j)))
				k = 4'(j);
	end

	always_ff @(posedge clk) begin
		seg_s1.l0 <= stop_level(th, k);
		seg_s1.l1 <= stop_level(th, k + 4'd1);
		{seg_s1.r0, seg_s1.g0, seg_s1.b0} <= stop_rgb(th, k);
		{seg_s1.r1, seg_s1.g1, seg_s1.b1} <= stop_rgb(th, k + 4'd1);
		idx_s1 <= idx;
	end

	logic [7:0] a, b;
	assign a = seg_s1.l1 - idx_s1;
	assign b = idx_s1 - seg_s1.l0;

	always_ff @(posedge clk) begin
		num_s2[0] <= {9'd0, seg_s1.r0} * a + {9'd0, seg_s1.r1} * b;
		num_s2[1] <= {9'd0, seg_s1.g0} * a + {9'd0, seg_s1.g1} * b;
		num_s2[2] <= {9'd0, seg_s1.b0} * a + {9'd0, seg_s1.b1} * b;
		den_s2 <= {1'b0, seg_s1.l1 - seg_s1.l0};
		idx_s2 <= idx_s1;
	end

	logic [17:0] rem_a [3];
	logic [3:0]  q_a [3];
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rem_a[c] = {num_s2[c], 1'b0} + {9'd0, den_s2};
			q_a[c]   = '0;
			for (int i = 3; i >= 0; i--) begin
				if (rem_a[c] >= ({8'd0, den_s2, 1'b0} << (i + 4))) begin
					rem_a[c]  = rem_a[c] - ({8'd0, den_s2, 1'b0} << (i + 4));
					q_a[c][i] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			rem_s3[c] <= rem_a[c];
			qhi_s3[c] <= q_a[c];
		end
		den_s3 <= den_s2;
		idx_s3 <= idx_s2;
	end

	logic [17:0] rem_b [3];
	logic [3:0]  q_b [3];
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rem_b[c] = rem_s3[c];
			q_b[c]   = '0;
			for (int i = 3; i >= 0; i--) begin
				if (rem_b[c] >= ({8'd0, den_s3, 1'b0} << i)) begin
					rem_b[c]  = rem_b[c] - ({8'd0, den_s3, 1'b0} << i);
					q_b[c][i] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++)
			ch_s4[c] <= {qhi_s3[c], q_b[c]};
		idx_s4 <= idx_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign out_vld = vld_s4;
	assign idx_out = idx_s4;
	assign red     = ch_s4[0];
	assign green   = ch_s4[1];
	assign blue    = ch_s4[2];
endmodule
`default_nettype wire

// ===== tb/sv/echogram_false_color_mapper_tb.sv =====
// Testbench for echogram_false_color_mapper: directed table, then random pixel streams
// checked against an internal window-level/palette predictor. Depends on src/efcm_pkg.sv,
// src/echogram_false_color_mapper.sv, src/efcm_remap.sv and src/efcm_blend.sv.
`timescale 1ns / 100ps
module echogram_false_color_mapper_tb;
	import efcm_pkg::*;

	localparam logic [1:0] REG_THEME = 2'd0;
	localparam logic [1:0] REG_LOW = 2'd1;
	localparam logic [1:0] REG_HIGH = 2'd2;
	localparam logic [1:0] REG_NONE = 2'd3;
	localparam int CycleLimit = 200000;

	typedef struct packed {
		logic [7:0] idx;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pixel_t;

	typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [1:0] reg_idx;
		logic [7:0] value;
		bit typed;
		pixel_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [7:0] intensity = 8'd0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = 2'd0;
	logic [6:0] cfg_data = 7'd0;
	logic busy, done;
	logic [7:0] level_index, red, green, blue;

	logic [3:0] sh_theme = 4'd0;
	logic [6:0] sh_low = 7'd10;
	logic [6:0] sh_high = 7'd100;

	pixel_t color_q[$];
	row_t rows[$];
	int errors = 0;
	int cycles = 0;
	bit no_idle = 1'b0;

	echogram_false_color_mapper DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .intensity(intensity),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
		.level_index(level_index), .red(red), .green(green), .blue(blue)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int n_stops(input int th);
		case (th)
			0: return 5;
			1: return 4;
			2: return 8;
			3: return 6;
			4, 5: return 3;
			6: return 11;
			7: return 9;
			default: return 10;
		endcase
	endfunction

	function automatic int lvl_at(input int th, input int k);
		logic [87:0] row;
		case (th)
			0: row = {8'd0, 8'd30, 8'd130, 8'd220, 8'd255, 48'd0};
			1: row = {8'd0, 8'd30, 8'd130, 8'd255, 56'd0};
			2: row = {8'd0, 8'd12, 8'd26, 8'd52, 8'd92, 8'd140, 8'd200, 8'd255, 24'd0};
			3: row = {8'd0, 8'd30, 8'd80, 8'd120, 8'd150, 8'd255, 40'd0};
			4, 5: row = {8'd0, 8'd150, 8'd255, 64'd0};
			6: row = {8'd0, 8'd18, 8'd36, 8'd60, 8'd90, 8'd120, 8'd150, 8'd185, 8'd210,
				8'd235, 8'd255};
			7: row = {8'd0, 8'd30, 8'd60, 8'd95, 8'd130, 8'd170, 8'd210, 8'd235, 8'd255,
				16'd0};
			8: row = {8'd0, 8'd20, 8'd45, 8'd70, 8'd100, 8'd130, 8'd160, 8'd190, 8'd220,
				8'd255, 8'd0};
			default: row = {8'd0, 8'd28, 8'd56, 8'd84, 8'd112, 8'd140, 8'd168, 8'd196,
				8'd224, 8'd255, 8'd0};
		endcase
		return int'(row[(10 - k) * 8 +: 8]);
	endfunction

	function automatic logic [23:0] rgb_at(input int th, input int k);
		logic [263:0] row;
		case (th)
			0: row = {24'h000000, 24'h140550, 24'h32B4E6, 24'hBEF0FA, 24'hFFFFFF, 144'd0};
			1: row = {24'h000000, 24'h32320A, 24'hE6C864, 24'hFFFFDC, 168'd0};
			2: row = {24'h000000, 24'h1C0A00, 24'h371200, 24'h5F2300, 24'h96460A,
				24'hD2690F, 24'hF5AF46, 24'hFFE8A0, 72'd0};
			3: row = {24'h000000, 24'h280050, 24'h001E96, 24'h14E61E, 24'hFF3214,
				24'hFFFFFF, 120'd0};
			4: row = {24'h000000, 24'hBEC8C8, 24'hE6FFFF, 192'd0};
			5: row = {24'hE6FFFF, 24'h464646, 24'h000000, 192'd0};
			6: row = {24'h000028, 24'h140078, 24'h2800C8, 24'h005AFF, 24'h00C8FF,
				24'h00FFC8, 24'h00FF50, 24'hDCFF00, 24'hFF7800, 24'hFF2828, 24'hFFFFFF};
			7: row = {24'h000046, 24'h002896, 24'h0064E6, 24'h00B4FF, 24'h00F0FF,
				24'h50FFE6, 24'hAAFFFF, 24'hE6FFFF, 24'hFFFFFF, 48'd0};
			8: row = {24'h000000, 24'h003200, 24'h006400, 24'h00A000, 24'h00DC00,
				24'h00FF00, 24'h78FF00, 24'hC8FF00, 24'hFFFF50, 24'hFFFFFF, 24'd0};
			default: row = {24'h3380FF, 24'h3366E6, 24'h4D4DCC, 24'h6633B3, 24'h803399,
				24'h994D80, 24'hB36666, 24'hCC804D, 24'hE69933, 24'hFFB31A, 24'd0};
		endcase
		return row[(10 - k) * 24 +: 24];
	endfunction

	function automatic pixel_t map_pixel(input logic [7:0] x);
		int th, ofs, d, idx, k, l0, l1, den, num, ch;
		logic [23:0] c0, c1;
		pixel_t p;
		th = (sh_theme < 4'd10) ? int'(sh_theme) : 0;
		ofs = (int'(sh_low) * 5) / 2;
		d = int'(x) - ofs;
		if (sh_high > sh_low) idx = (d * 100) / (int'(sh_high) - int'(sh_low));
		else idx = d * 10000;
		if (idx < 0) idx = 0;
		if (idx > 255) idx = 255;
		k = 0;
		while (k + 2 < n_stops(th) && idx > lvl_at(th, k + 1)) k++;
		l0 = lvl_at(th, k);
		l1 = lvl_at(th, k + 1);
		c0 = rgb_at(th, k);
		c1 = rgb_at(th, k + 1);
		den = l1 - l0;
		p.idx = idx[7:0];
		for (ch = 0; ch < 3; ch++) begin
			num = int'(c0[(2 - ch) * 8 +: 8]) * (l1 - idx) + int'(c1[(2 - ch) * 8 +: 8]) * (idx - l0);
			num = (2 * num + den) / (2 * den);
			if (ch == 0) p.r = num[7:0];
			else if (ch == 1) p.g = num[7:0];
			else p.b = num[7:0];
		end
		return p;
	endfunction

	always @(posedge clk) begin
		pixel_t got, want;
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
		if (done) begin
			got = '{level_index, red, green, blue};
			if (color_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
			end else begin
				want = color_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected idx %0d rgb %0d,%0d,%0d got idx %0d rgb %0d,%0d,%0d",
							want.idx, want.r, want.g, want.b, got.idx, got.r, got.g, got.b);
				end
			end
		end
	end

	task automatic send_pixel(input logic [7:0] x, input bit typed, input pixel_t want);
		while (!no_idle && $urandom_range(0, 99) < 17) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		intensity <= x;
		@(posedge clk);
		while (busy) @(posedge clk);
		color_q.push_back(typed ? want : map_pixel(x));
	endtask

	task automatic write_reg(input logic [1:0] ri, input logic [6:0] v);
		start <= 1'b0;
		while (color_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ri;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (ri)
			REG_THEME: sh_theme = v[3:0];
			REG_LOW: sh_low = v;
			REG_HIGH: sh_high = v;
			default: ;
		endcase
	endtask

	function automatic void add_cfg(input logic [1:0] ri, input logic [7:0] v);
		rows.push_back('{ROW_CFG, ri, v, 1'b0, '0});
	endfunction

	function automatic void add_px(input logic [7:0] x, input bit typed, input pixel_t want);
		rows.push_back('{ROW_PIXEL, 2'd0, x, typed, want});
	endfunction

	function automatic logic [6:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 7'd0;
			1: return 7'd100;
			2: return 7'd127;
			default: return 7'($urandom_range(0, 127));
		endcase
	endfunction

	initial begin
		int ph, n, lo, hi;
		logic [7:0] x;
		row_t rw;

		add_px(8'd0, 1, '{8'd0, 8'd0, 8'd0, 8'd0});
		add_px(8'd255, 1, '{8'd255, 8'd255, 8'd255, 8'd255});
		add_px(8'd25, 1, '{8'd0, 8'd0, 8'd0, 8'd0});
		add_px(8'd100, 0, '0);
		add_cfg(REG_THEME, 8'd5);
		add_px(8'd255, 1, '{8'd255, 8'd0, 8'd0, 8'd0});
		add_px(8'd0, 1, '{8'd0, 8'd230, 8'd255, 8'd255});
		add_cfg(REG_THEME, 8'd12);
		add_px(8'd255, 1, '{8'd255, 8'd255, 8'd255, 8'd255});
		add_px(8'd130, 0, '0);
		add_cfg(REG_NONE, 8'd127);
		add_cfg(REG_LOW, 8'd50);
		add_cfg(REG_HIGH, 8'd50);
		add_px(8'd125, 1, '{8'd0, 8'd0, 8'd0, 8'd0});
		add_px(8'd126, 1, '{8'd255, 8'd255, 8'd255, 8'd255});
		add_cfg(REG_LOW, 8'd127);
		add_cfg(REG_HIGH, 8'd0);
		add_px(8'd255, 1, '{8'd0, 8'd0, 8'd0, 8'd0});
		add_cfg(REG_LOW, 8'd0);
		add_cfg(REG_HIGH, 8'd127);
		add_px(8'd0, 1, '{8'd0, 8'd0, 8'd0, 8'd0});
		add_px(8'd255, 0, '0);
		add_cfg(REG_THEME, 8'd9);
		add_px(8'd0, 1, '{8'd0, 8'd51, 8'd128, 8'd255});
		add_px(8'd170, 0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			rw = rows[i];
			if (rw.kind == ROW_CFG) write_reg(rw.reg_idx, rw.value[6:0]);
			else send_pixel(rw.value, rw.typed, rw.want);
		end

		for (ph = 0; ph < 14; ph++) begin
			write_reg(REG_THEME, (ph < 10) ? 7'(ph) : 7'($urandom_range(0, 127)));
			if ($urandom_range(0, 3) == 0) begin
				lo = pick_level();
				hi = pick_level();
			end else begin
				lo = $urandom_range(0, 90);
				hi = $urandom_range(lo + 1, 127);
			end
			write_reg(REG_LOW, 7'(lo));
			write_reg(REG_HIGH, 7'(hi));
			if (ph % 5 == 4) write_reg(REG_NONE, 7'($urandom_range(0, 127)));
			no_idle = (ph == 6 || ph == 7);
			for (n = 0; n < 100; n++) begin
				if ($urandom_range(0, 9) == 0) x = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				else x = 8'($urandom_range(0, 255));
				send_pixel(x, 0, '0);
			end
		end

		start <= 1'b0;
		while (color_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
